[rtl/imu_frame_parser_ema_macros.svh]
// Assertion macros for the IMU frame parser.
// Used by the modules of the parser; expects i_clk and i_rst_n in scope.
`ifndef IMU_FRAME_PARSER_EMA_MACROS_SVH
`define IMU_FRAME_PARSER_EMA_MACROS_SVH

// same-cycle implication, off while in reset
`define IFP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define IFP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/imu_fp_pkg.sv]
// Shared types and constants of the IMU frame parser.
// No dependencies; imported by the front, queue, back and top modules.
package imu_fp_pkg;

    localparam logic [7:0] HDR_BYTE  = 8'h55;
    localparam logic [7:0] ID_ACC    = 8'h51;
    localparam logic [7:0] ID_GYRO   = 8'h52;
    localparam logic [7:0] ID_ANGLE  = 8'h53;
    localparam logic [7:0] ID_MAG    = 8'h54;
    localparam logic [7:0] ID_PRESS  = 8'h56;
    localparam logic [7:0] ID_QUAT   = 8'h59;

    localparam int          PKT_LEN    = 11;
    localparam logic [3:0]  LAST_IDX   = 4'(PKT_LEN - 1);

    localparam int          ALPHA_W     = 17;
    localparam logic [16:0] ALPHA_RESET = 17'd9830;
    localparam logic [16:0] ALPHA_ONE   = 17'd65536;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        KIND_ACC   = 3'd0,
        KIND_GYRO  = 3'd1,
        KIND_ANGLE = 3'd2,
        KIND_MAG   = 3'd3,
        KIND_PRESS = 3'd4,
        KIND_QUAT  = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [3:0][15:0] words;
    } t_frame;

    function automatic logic type_known(input logic [7:0] t);
        return (t == ID_ACC) || (t == ID_GYRO) || (t == ID_ANGLE) ||
               (t == ID_MAG) || (t == ID_PRESS) || (t == ID_QUAT);
    endfunction

    function automatic t_kind type_kind(input logic [7:0] t);
        t_kind k;
        k = KIND_ACC;
        unique case (t)
            ID_GYRO:  k = KIND_GYRO;
            ID_ANGLE: k = KIND_ANGLE;
            ID_MAG:   k = KIND_MAG;
            ID_PRESS: k = KIND_PRESS;
            ID_QUAT:  k = KIND_QUAT;
            default:  k = KIND_ACC;
        endcase
        return k;
    endfunction

endpackage

[rtl/imu_fp_front.sv]
// Front end: header hunt, byte collection, running checksum and type check.
// Depends on imu_fp_pkg and the assertion macros; feeds imu_fp_queue.
`include "imu_frame_parser_ema_macros.svh"

module imu_fp_front import imu_fp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_mode,
    input  logic [7:0] i_data_byte,
    input  logic       i_full,
    output logic       o_stall,
    output logic       o_push,
    output t_frame     o_frame
);

    logic       r_in_sync, n_in_sync;
    logic [3:0] r_count, n_count;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_type;
    logic [7:0] r_data [0:7];
    logic       accept;
    logic       store;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign store   = accept && !i_mode && r_in_sync && (r_count != LAST_IDX);

    always_comb begin
        n_in_sync = r_in_sync;
        n_count   = r_count;
        n_sum     = r_sum;
        o_push    = 1'b0;
        if (accept) begin
            priority if (i_mode) begin
                n_in_sync = 1'b0;
                n_count   = '0;
                n_sum     = '0;
            end else if (!r_in_sync) begin
                if (i_data_byte == HDR_BYTE) begin
                    n_in_sync = 1'b1;
                    n_count   = 4'd1;
                    n_sum     = i_data_byte;
                end
            end else if (r_count == LAST_IDX) begin
                n_in_sync = 1'b0;
                n_count   = '0;
                n_sum     = '0;
                o_push    = (i_data_byte == r_sum) && type_known(r_type);
            end else begin
                n_count = r_count + 4'd1;
                n_sum   = r_sum + i_data_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_sync <= 1'b0;
            r_count   <= '0;
            r_sum     <= '0;
        end else begin
            r_in_sync <= n_in_sync;
            r_count   <= n_count;
            r_sum     <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store) begin
            if (r_count == 4'd1) begin
                r_type <= i_data_byte;
            end else begin
                r_data[3'(r_count - 4'd2)] <= i_data_byte;
            end
        end
    end

    always_comb begin
        o_frame.kind = type_kind(r_type);
        for (int i = 0; i < 4; i++) begin
            o_frame.words[i] = {r_data[2 * i + 1], r_data[2 * i]};
        end
    end

    `IFP_ASSERT_IMP(a_front_idle_clear, !r_in_sync, (r_count == 4'd0) && (r_sum == 8'd0), "front: idle with residue")
    `IFP_ASSERT_IMP(a_front_push_at_end, o_push, r_in_sync && (r_count == LAST_IDX) && !i_full, "front: push off frame end")

endmodule

[rtl/imu_fp_queue.sv]
// Short frame queue between front and back end.
// Depends on imu_fp_pkg and the assertion macros.
`include "imu_frame_parser_ema_macros.svh"

module imu_fp_queue import imu_fp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_frame i_frame,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_avail,
    output t_frame o_frame
);

    t_frame                r_mem [0:QUEUE_DEPTH-1];
    logic [QUEUE_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QUEUE_AW:0]     r_count;

    function automatic logic [QUEUE_AW-1:0] ptr_next(input logic [QUEUE_AW-1:0] p);
        return (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_avail = (r_count != '0);
    assign o_frame = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= ptr_next(r_wr_ptr);
            if (i_pop) r_rd_ptr <= ptr_next(r_rd_ptr);
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_frame;
    end

    `IFP_ASSERT_IMP(a_queue_pop_nonempty, i_pop, r_count != '0, "queue: pop while empty")
    `IFP_ASSERT_NXT(a_queue_fill, i_push && !i_pop, r_count == $past(r_count) + 1'b1, "queue: count slip")

endmodule

[rtl/imu_fp_back.sv]
// Back end: fixed-point conversion, EMA filter state and output register.
// Depends on imu_fp_pkg and the assertion macros; reads imu_fp_queue.
`include "imu_frame_parser_ema_macros.svh"

module imu_fp_back import imu_fp_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [ALPHA_W-1:0]  i_cfg_wr_data,
    input  logic                i_avail,
    input  t_frame              i_frame,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [2:0]          o_kind,
    output logic signed [31:0]  o_value_0,
    output logic signed [31:0]  o_value_1,
    output logic signed [31:0]  o_value_2,
    output logic signed [31:0]  o_value_3,
    output logic [31:0]         o_pressure_value,
    output logic [31:0]         o_altitude_value
);

    localparam int FXW = (FRAC_BITS > 15) ? FRAC_BITS + 17 : 33;
    localparam int DW  = 33;
    localparam int PW  = DW + ALPHA_W + 1;
    localparam int QW  = PW - 16;

    typedef enum logic [2:0] {
        SLOT_ACC_X, SLOT_ACC_Y, SLOT_GYRO_X, SLOT_GYRO_Y, SLOT_GYRO_Z,
        SLOT_ROLL, SLOT_PITCH
    } t_slot;

    function automatic logic signed [31:0] to_fixed(input logic [15:0] w);
        logic signed [FXW-1:0] e;
        logic signed [FXW-1:0] s;
        e = FXW'($signed(w));
        s = e <<< FRAC_BITS;
        if (s > FXW'(33'sh0_7FFF_FFFF)) return 32'sh7FFF_FFFF;
        if (s < FXW'(33'sh1_8000_0000)) return 32'sh8000_0000;
        return 32'(s);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [QW:0] v);
        if (v > (QW + 1)'(33'sh0_7FFF_FFFF)) return 32'sh7FFF_FFFF;
        if (v < (QW + 1)'(33'sh1_8000_0000)) return 32'sh8000_0000;
        return 32'(v);
    endfunction

    logic [ALPHA_W-1:0]    r_alpha;
    logic [ALPHA_W-1:0]    alpha_c;
    logic signed [31:0]    r_filt [0:6];

    logic signed [31:0]    fx   [0:3];
    logic signed [31:0]    prev [0:2];
    logic signed [PW-1:0]  prod [0:2];

    logic                  r_s1_valid;
    t_kind                 r_s1_kind;
    logic signed [31:0]    r_s1_fx   [0:3];
    logic signed [31:0]    r_s1_prev [0:2];
    logic signed [PW-1:0]  r_s1_prod [0:2];
    logic [3:0][15:0]      r_s1_words;

    logic signed [31:0]    upd [0:2];
    logic                  s1_move;
    logic                  r_out_valid;
    t_kind                 r_out_kind;

    logic signed [31:0]    n_val [0:3];
    logic [31:0]           n_pv, n_av;
    logic signed [31:0]    r_val [0:3];
    logic [31:0]           r_pv, r_av;

    assign alpha_c = (r_alpha > ALPHA_ONE) ? ALPHA_ONE : r_alpha;
    assign o_pop   = i_avail && !r_s1_valid;
    assign s1_move = r_s1_valid && (!r_out_valid || !i_stall);

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            fx[i] = to_fixed(i_frame.words[i]);
        end
        prev[0] = r_filt[SLOT_ACC_X];
        prev[1] = r_filt[SLOT_ACC_Y];
        prev[2] = r_filt[SLOT_GYRO_Z];
        unique case (i_frame.kind)
            KIND_GYRO: begin
                prev[0] = r_filt[SLOT_GYRO_X];
                prev[1] = r_filt[SLOT_GYRO_Y];
            end
            KIND_ANGLE: begin
                prev[0] = r_filt[SLOT_ROLL];
                prev[1] = r_filt[SLOT_PITCH];
            end
            default: ;
        endcase
        for (int i = 0; i < 3; i++) begin
            prod[i] = PW'(DW'(fx[i]) - DW'(prev[i])) * $signed({1'b0, alpha_c});
        end
    end

    always_comb begin
        logic signed [PW-1:0] rnd;
        for (int i = 0; i < 3; i++) begin
            rnd    = (r_s1_prod[i] + PW'(32768)) >>> 16;
            upd[i] = sat32((QW + 1)'(r_s1_prev[i]) + (QW + 1)'($signed(rnd[QW-1:0])));
        end
    end

    always_comb begin
        n_val[0] = r_s1_fx[0];
        n_val[1] = r_s1_fx[1];
        n_val[2] = r_s1_fx[2];
        n_val[3] = '0;
        n_pv     = '0;
        n_av     = '0;
        unique case (r_s1_kind)
            KIND_ACC: begin
                n_val[0] = upd[0];
                n_val[1] = upd[1];
                n_val[3] = r_s1_fx[3];
            end
            KIND_GYRO: begin
                n_val[0] = upd[0];
                n_val[1] = upd[1];
                n_val[2] = upd[2];
            end
            KIND_ANGLE: begin
                n_val[0] = upd[0];
                n_val[1] = upd[1];
            end
            KIND_PRESS: begin
                n_pv = {r_s1_words[1], r_s1_words[0]};
                n_av = {r_s1_words[3], r_s1_words[2]};
            end
            KIND_QUAT: begin
                n_val[3] = r_s1_fx[3];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha     <= ALPHA_RESET;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 7; i++) r_filt[i] <= '0;
        end else begin
            if (i_cfg_wr_en) r_alpha <= i_cfg_wr_data;
            if (o_pop) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (s1_move) begin
                unique case (r_s1_kind)
                    KIND_ACC: begin
                        r_filt[SLOT_ACC_X] <= upd[0];
                        r_filt[SLOT_ACC_Y] <= upd[1];
                    end
                    KIND_GYRO: begin
                        r_filt[SLOT_GYRO_X] <= upd[0];
                        r_filt[SLOT_GYRO_Y] <= upd[1];
                        r_filt[SLOT_GYRO_Z] <= upd[2];
                    end
                    KIND_ANGLE: begin
                        r_filt[SLOT_ROLL]  <= upd[0];
                        r_filt[SLOT_PITCH] <= upd[1];
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_kind  <= i_frame.kind;
            r_s1_words <= i_frame.words;
            for (int i = 0; i < 4; i++) r_s1_fx[i] <= fx[i];
            for (int i = 0; i < 3; i++) begin
                r_s1_prev[i] <= prev[i];
                r_s1_prod[i] <= prod[i];
            end
        end
        if (s1_move) begin
            r_out_kind <= r_s1_kind;
            for (int i = 0; i < 4; i++) r_val[i] <= n_val[i];
            r_pv       <= n_pv;
            r_av       <= n_av;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_kind           = r_out_kind;
    assign o_value_0        = r_val[0];
    assign o_value_1        = r_val[1];
    assign o_value_2        = r_val[2];
    assign o_value_3        = r_val[3];
    assign o_pressure_value = r_pv;
    assign o_altitude_value = r_av;

    `IFP_ASSERT_IMP(a_back_press_only, r_out_valid && (r_out_kind != KIND_PRESS), (o_pressure_value == 32'd0) && (o_altitude_value == 32'd0), "back: pressure words on other kind")
    `IFP_ASSERT_NXT(a_back_hold, r_out_valid && i_stall && !s1_move, r_out_valid && $stable(o_value_0), "back: stalled result lost")

endmodule

[rtl/imu_frame_parser_ema.sv]
// IMU frame parser with EMA smoothing. Takes one serial byte (or a resync)
// per cycle while o_stall is low and returns one decoded result per good
// eleven-byte frame. The front end checks the header, checksum and type as
// bytes arrive and pushes a good frame into a two-entry queue at the edge
// that takes its checksum byte; the back end pops a frame into its multiply
// stage only while it is empty, then runs the filter update into the output
// register (o_valid) unless the output is stalled. o_stall rises only when
// the queue holds two frames still waiting for the back end, which with
// eleven bytes per frame happens only under a long output stall. The user must
// write the smoothing factor only while idle; the block does not enforce it.
// Depends on imu_fp_pkg, imu_fp_front, imu_fp_queue and imu_fp_back.

module imu_frame_parser_ema import imu_fp_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [16:0]         i_cfg_wr_data,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_mode,
    input  logic [7:0]          i_data_byte,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [2:0]          o_kind,
    output logic signed [31:0]  o_value_0,
    output logic signed [31:0]  o_value_1,
    output logic signed [31:0]  o_value_2,
    output logic signed [31:0]  o_value_3,
    output logic [31:0]         o_pressure_value,
    output logic [31:0]         o_altitude_value
);

    logic   q_full;
    logic   q_push;
    logic   q_pop;
    logic   q_avail;
    t_frame front_frame;
    t_frame head_frame;

    imu_fp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_mode      (i_mode),
        .i_data_byte (i_data_byte),
        .i_full      (q_full),
        .o_stall     (o_stall),
        .o_push      (q_push),
        .o_frame     (front_frame)
    );

    imu_fp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_frame (front_frame),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_avail (q_avail),
        .o_frame (head_frame)
    );

    imu_fp_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_avail          (q_avail),
        .i_frame          (head_frame),
        .o_pop            (q_pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_kind           (o_kind),
        .o_value_0        (o_value_0),
        .o_value_1        (o_value_1),
        .o_value_2        (o_value_2),
        .o_value_3        (o_value_3),
        .o_pressure_value (o_pressure_value),
        .o_altitude_value (o_altitude_value)
    );

endmodule
